@@ rtl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue.
// No dependencies; imported by every other file of the block.
package spq_pkg;

	localparam int CAPACITY = 128;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ID_W     = 8;
	localparam int URG_W    = 3;
	localparam int AGE_W    = 8;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_SERVED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_SERVE  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [URG_W-1:0] urg;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [URG_W-1:0] urg;
		logic [AGE_W-1:0] age;
	} result_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
	} mem_req_t;

	// id of a new entry: count + 1, kept to its low ID_W bits
	function automatic logic [ID_W-1:0] next_id(input logic [CNT_W-1:0] cnt);
		logic [CNT_W:0] sum;
		sum = {1'b0, cnt} + (CNT_W + 1)'(1);
		return ID_W'(sum);
	endfunction

endpackage

@@ rtl/spq_req_if.sv @@
// Request channel of the priority queue: valid/ready plus one request beat.
// Depends on spq_pkg for field widths.
interface spq_req_if
	import spq_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             func;
	logic [URG_W-1:0] urgency;
	logic [AGE_W-1:0] age_years;

	modport source (output valid, func, urgency, age_years, input ready);
	modport sink   (input valid, func, urgency, age_years, output ready);
endinterface

@@ rtl/spq_rsp_if.sv @@
// Response channel of the priority queue: valid/ready plus one result beat.
// Depends on spq_pkg for field widths.
interface spq_rsp_if
	import spq_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [ID_W-1:0]  entry_id;
	logic [URG_W-1:0] entry_urgency;
	logic [AGE_W-1:0] entry_age;

	modport source (output valid, status, entry_id, entry_urgency, entry_age, input ready);
	modport sink   (input valid, status, entry_id, entry_urgency, entry_age, output ready);
endinterface

@@ rtl/spq_store.sv @@
// Entry memory: one write port, one read port, registered read data.
// Depends on spq_pkg.
module spq_store
	import spq_pkg::*;
(
	input  logic     clk,
	input  mem_req_t mreq,
	output entry_t   rd_data
);

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.re) begin
			rd_data <= mem[mreq.raddr];
		end
	end

endmodule

@@ rtl/spq_ctrl.sv @@
// Sequencer: insert writes, serve scan for minimum urgency, then compaction.
// Depends on spq_pkg and spq_req_if; drives spq_store through mem_req_t.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink  req,
	output mem_req_t mreq,
	input  entry_t   rd_data,
	output logic     res_valid,
	output result_t  res,
	input  logic     res_ack
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              rd_v_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [ADDR_W-1:0] best_idx_q;
	entry_t            best_q;
	result_t           res_q;

	logic accept, is_insert, full, issue, sweep_done, better;

	assign accept     = req.valid && req.ready;
	assign is_insert  = (func_t'(req.func) == FN_INSERT);
	assign full       = (cnt_q >= CNT_W'(CAPACITY));
	assign issue      = ((state_q == S_SCAN) || (state_q == S_MOVE)) && (rd_idx_q < cnt_q);
	assign sweep_done = (rd_idx_q >= cnt_q) && !rd_v_s1;
	assign better     = (idx_s1 == '0) || (rd_data.urg < best_q.urg);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!is_insert && (cnt_q != '0)) state_d = S_SCAN;
					else                             state_d = S_RESULT;
				end
			end
			S_SCAN:   if (sweep_done) state_d = S_MOVE;
			S_MOVE:   if (sweep_done) state_d = S_RESULT;
			S_RESULT: if (res_ack)    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready  = 1'b0;
		res_valid  = 1'b0;
		mreq.re    = issue;
		mreq.raddr = rd_idx_q[ADDR_W-1:0];
		mreq.we    = 1'b0;
		mreq.waddr = cnt_q[ADDR_W-1:0];
		mreq.wdata = '{id: next_id(cnt_q), urg: req.urgency, age: req.age_years};
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				mreq.we   = accept && is_insert && !full;
			end
			S_MOVE: begin
				// entry read at idx moves up one place
				mreq.we    = rd_v_s1;
				mreq.waddr = ADDR_W'(idx_s1 - ADDR_W'(1));
				mreq.wdata = rd_data;
			end
			S_RESULT: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (state_q == S_IDLE && accept && is_insert && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == S_MOVE && sweep_done) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				rd_idx_q <= '0;
				if (accept) begin
					if (is_insert) begin
						if (full) res_q <= '{ST_FULL, '0, '0, '0};
						else      res_q <= '{ST_INSERTED, next_id(cnt_q), '0, '0};
					end else begin
						res_q <= '{ST_EMPTY, '0, '0, '0};
					end
				end
			end
			S_SCAN: begin
				if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
				// strict compare keeps the earliest of equal urgencies
				if (rd_v_s1 && better) begin
					best_q     <= rd_data;
					best_idx_q <= idx_s1;
				end
				if (sweep_done) rd_idx_q <= CNT_W'(best_idx_q) + CNT_W'(1);
			end
			S_MOVE: begin
				if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
				if (sweep_done) res_q <= '{ST_SERVED, best_q.id, best_q.urg, best_q.age};
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/stable_priority_queue_unit.sv @@
// Stable priority queue, top level: request port, entry memory, sequencer
// and the response register. Depends on spq_pkg, spq_req_if, spq_rsp_if,
// spq_store and spq_ctrl.
//
// Holds up to CAPACITY (128) entries of {id, urgency, age} in a single-port-
// read, single-port-write memory. An insert beat stores its entry behind the
// others and returns id = count + 1 (status full when the store is full). A
// serve beat returns the stored entry with the smallest urgency value, the
// oldest one among equals, and closes the gap (status empty when nothing is
// stored). One request is in work at a time; req.ready is high only while
// the sequencer is idle. A serve's run time is set by the memory's one
// read port: the minimum scan reads each stored entry once, then
// compaction reads and rewrites every entry behind the winner.
// The response register frees the sequencer, so a new request can be taken
// while a result beat still waits for rsp.ready. No clearing pass after
// reset: only entries below the count are ever read.
module stable_priority_queue_unit
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	mem_req_t mreq;
	entry_t   rd_data;
	logic     res_valid;
	result_t  res;
	logic     res_ack;

	logic     rsp_v_q;
	result_t  rsp_q;

	spq_store u_store (
		.clk     (clk),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mreq      (mreq),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res       (res),
		.res_ack   (res_ack)
	);

	// result moves into the response register once it is empty or draining
	assign res_ack = res_valid && (!rsp_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (res_ack) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.entry_id      = rsp_q.id;
	assign rsp.entry_urgency = rsp_q.urg;
	assign rsp.entry_age     = rsp_q.age;

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checks for stable_priority_queue_unit, attached by bind.
// Depends on spq_pkg.
module spq_checker
	import spq_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       status,
	input logic [ID_W-1:0]  entry_id,
	input logic [URG_W-1:0] entry_urgency,
	input logic [AGE_W-1:0] entry_age
);

	// one request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped before taken");

	a_no_entry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_SERVED) |-> (entry_urgency == '0) && (entry_age == '0))
		else $error("entry fields set on a non-serve result");

	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((status == ST_FULL) || (status == ST_EMPTY)) |-> (entry_id == '0))
		else $error("id set on a full or empty result");

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.entry_id      (rsp.entry_id),
	.entry_urgency (rsp.entry_urgency),
	.entry_age     (rsp.entry_age)
);
